FILE: hdl/fault_injecting_bit_memory_macros.svh
// ----------------------------------------------------------------------------
// fault injecting bit memory assertion macros
// immediate-style wrappers for concurrent checks on clk and rst_n
// ----------------------------------------------------------------------------
`ifndef FAULT_INJECTING_BIT_MEMORY_MACROS_SVH
`define FAULT_INJECTING_BIT_MEMORY_MACROS_SVH
`ifndef SYNTHESIS
`define FIBM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define FIBM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FIBM_ASSERT_SAME(lbl, ante, cons)
`define FIBM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: hdl/fibm_pkg.sv
// ----------------------------------------------------------------------------
// fibm_pkg
// shared constants, types and helpers of the fault injecting bit memory
// ----------------------------------------------------------------------------
package fibm_pkg;

  localparam int WORDS      = 1024;
  localparam int MAX_FAULTS = 16;
  localparam int AW         = $clog2(WORDS);
  localparam int FW         = (MAX_FAULTS > 1) ? $clog2(MAX_FAULTS) : 1;
  localparam int CW         = $clog2(MAX_FAULTS + 1);

  localparam logic [31:0] STATE_CODE_MIN = 32'hC000_0000;

  localparam logic [2:0] K_RD_BIT  = 3'd0;
  localparam logic [2:0] K_WR_BIT  = 3'd1;
  localparam logic [2:0] K_RD_WORD = 3'd2;
  localparam logic [2:0] K_WR_WORD = 3'd3;
  localparam logic [2:0] K_ADD     = 3'd4;

  localparam logic [2:0] OP_RD0    = 3'd4;
  localparam logic [2:0] OP_RD1    = 3'd5;
  localparam logic [2:0] OP_STATE0 = 3'd6;
  localparam logic [2:0] OP_STATE1 = 3'd7;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_SINGLE,
    ACT_STATE,
    ACT_CHK_VIC,
    ACT_CHK_AGG
  } act_t;

  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_CLEAR,
    CMD_CAPTURE,
    CMD_LOAD,
    CMD_CODE,
    CMD_EVAL,
    CMD_CHK,
    CMD_PUT,
    CMD_FIN_RD,
    CMD_FIN_WR,
    CMD_OUT
  } cmd_t;

  typedef struct packed {
    logic bit_access;
    logic is_write;
    logic scan_done;
    logic need_chk;
    logic need_put;
    logic chk_put;
    logic clr_done;
  } dp_sts_t;

  function automatic logic state_match(logic [31:0] c, logic b);
    return (c[31:29] == OP_STATE0 && !b) || (c[31:29] == OP_STATE1 && b);
  endfunction

  function automatic logic [7:0] set_bit(logic [7:0] d, logic [2:0] c, logic b);
    return (d & ~(8'b1 << c)) | (8'(b) << c);
  endfunction

endpackage

FILE: hdl/fault_injecting_bit_memory.sv
// ----------------------------------------------------------------------------
// fault_injecting_bit_memory
// byte memory with bit accesses and injected single- and two-cell faults
// ----------------------------------------------------------------------------
//  channel | ports                         | handshake
//  input   | in_kind .. in_read_value      | in_valid / in_stall
//  result  | out_sensed_bit .. out_status  | out_valid / out_stall
//
//  word and fault ops pass through capture, load and output steps
//  a bit access adds a code step and a scan over the stored fault entries,
//  plus a final read and write for a bit write; the scan shares the memory ports
//  after reset a clearing pass over all 1024 words runs before the first word is taken
//  a stalled result holds; the next word is taken once the block is idle
module fault_injecting_bit_memory (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic [9:0]  in_word_index,
  input  logic [2:0]  in_cell_req,
  input  logic        in_bit_value,
  input  logic [7:0]  in_word_value,
  input  logic [31:0] in_aggressor_code,
  input  logic [31:0] in_victim_code,
  input  logic        in_fault_value,
  input  logic        in_read_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_sensed_bit,
  output logic [7:0]  out_read_word,
  output logic [31:0] out_last_code,
  output logic [1:0]  out_status
);

  `include "fault_injecting_bit_memory_macros.svh"

  fibm_pkg::cmd_t    cmd;
  fibm_pkg::dp_sts_t sts;

  fibm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  fibm_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_kind           (in_kind),
    .in_word_index     (in_word_index),
    .in_cell_req       (in_cell_req),
    .in_bit_value      (in_bit_value),
    .in_word_value     (in_word_value),
    .in_aggressor_code (in_aggressor_code),
    .in_victim_code    (in_victim_code),
    .in_fault_value    (in_fault_value),
    .in_read_value     (in_read_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sensed_bit    (out_sensed_bit),
    .out_read_word     (out_read_word),
    .out_last_code     (out_last_code),
    .out_status        (out_status)
  );

  `FIBM_ASSERT_NEXT(a_one_word_at_a_time, in_valid && !in_stall, in_stall)
  `FIBM_ASSERT_SAME(a_status_code, out_valid, out_status != 2'd3)
  `FIBM_ASSERT_SAME(a_bit_or_word, out_valid, out_sensed_bit == 1'b0 || out_read_word == 8'd0)

endmodule

FILE: hdl/fibm_datapath.sv
// ----------------------------------------------------------------------------
// fibm_datapath
// cell memory, fault table, item and scan registers, result register
// ----------------------------------------------------------------------------
module fibm_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fibm_pkg::cmd_t       cmd,
  output fibm_pkg::dp_sts_t    sts,
  input  logic [2:0]           in_kind,
  input  logic [9:0]           in_word_index,
  input  logic [2:0]           in_cell_req,
  input  logic                 in_bit_value,
  input  logic [7:0]           in_word_value,
  input  logic [31:0]          in_aggressor_code,
  input  logic [31:0]          in_victim_code,
  input  logic                 in_fault_value,
  input  logic                 in_read_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_sensed_bit,
  output logic [7:0]           out_read_word,
  output logic [31:0]          out_last_code,
  output logic [1:0]           out_status
);

  logic [7:0]  mem [fibm_pkg::WORDS];
  logic [7:0]  rd_data_r;

  logic [31:0] fa_r [fibm_pkg::MAX_FAULTS];
  logic [31:0] fvc_r [fibm_pkg::MAX_FAULTS];
  logic [1:0]  fo_r [fibm_pkg::MAX_FAULTS];
  logic [fibm_pkg::CW-1:0] count_r;
  logic [31:0] last_r;

  logic [2:0]  kind_r;
  logic [9:0]  idx_r;
  logic [2:0]  cell_r;
  logic        bv_r;
  logic [7:0]  wv_r;
  logic [31:0] sa_r;
  logic [31:0] sv_r;
  logic        fv_r;
  logic        rv_r;

  logic [31:0] code_r;
  logic        val_r;
  logic [fibm_pkg::CW-1:0] scan_r;
  fibm_pkg::act_t act_r;
  logic [1:0]  status_r;
  logic [fibm_pkg::AW-1:0] clr_r;

  logic        out_valid_r;
  logic        out_bit_r;
  logic [7:0]  out_word_r;
  logic [31:0] out_code_r;
  logic [1:0]  out_status_r;

  logic [fibm_pkg::FW-1:0] ent;
  logic [31:0] sa_e, sv_e;
  logic        fv_e, rv_e;
  logic        touch, is_write, idx_ok, add_oor, full, hit;
  logic [31:0] ck;
  fibm_pkg::act_t act;
  logic [1:0]  status_nxt;
  logic        we, re;
  logic [fibm_pkg::AW-1:0] wa, ra, idx_a;
  logic [7:0]  wd;

  assign ent      = scan_r[fibm_pkg::FW-1:0];
  assign sa_e     = fa_r[ent];
  assign sv_e     = fvc_r[ent];
  assign fv_e     = fo_r[ent][0];
  assign rv_e     = fo_r[ent][1];
  assign is_write = (kind_r == fibm_pkg::K_WR_BIT);
  assign idx_ok   = 32'(idx_r) < fibm_pkg::WORDS;
  assign idx_a    = fibm_pkg::AW'(idx_r);
  assign add_oor  = (32'(sa_r[28:3]) >= fibm_pkg::WORDS) ||
                    (sv_r != 32'd0 && 32'(sv_r[28:3]) >= fibm_pkg::WORDS);
  assign full     = count_r >= fibm_pkg::CW'(fibm_pkg::MAX_FAULTS);
  assign touch    = (sa_e[28:3] == 26'(idx_r)) ||
                    (sv_e != 32'd0 && sv_e[28:3] == 26'(idx_r));
  assign ck       = (act_r == fibm_pkg::ACT_CHK_VIC) ? sv_e : sa_e;
  assign hit      = fibm_pkg::state_match(ck, rd_data_r[ck[2:0]]);

  always_comb begin
    act = fibm_pkg::ACT_NONE;
    if (touch) begin
      if (sv_e == 32'd0) begin
        if (code_r == sa_e) begin
          act = fibm_pkg::ACT_SINGLE;
        end else if (is_write && sa_e >= fibm_pkg::STATE_CODE_MIN && sa_e[2:0] == cell_r &&
                     fibm_pkg::state_match(sa_e, val_r)) begin
          act = fibm_pkg::ACT_STATE;
        end
      end else if (code_r == sa_e) begin
        if (sv_e >= fibm_pkg::STATE_CODE_MIN) act = fibm_pkg::ACT_CHK_VIC;
      end else if (code_r == sv_e) begin
        if (sa_e >= fibm_pkg::STATE_CODE_MIN) act = fibm_pkg::ACT_CHK_AGG;
      end
    end
  end

  always_comb begin
    status_nxt = fibm_pkg::ST_OK;
    if (kind_r <= fibm_pkg::K_WR_WORD && !idx_ok) status_nxt = fibm_pkg::ST_RANGE;
    else if (kind_r == fibm_pkg::K_ADD && add_oor) status_nxt = fibm_pkg::ST_RANGE;
    else if (kind_r == fibm_pkg::K_ADD && full) status_nxt = fibm_pkg::ST_FULL;
  end

  assign sts.bit_access = (kind_r <= fibm_pkg::K_WR_BIT) && idx_ok;
  assign sts.is_write   = is_write;
  assign sts.scan_done  = scan_r >= count_r;
  assign sts.need_chk   = (act == fibm_pkg::ACT_CHK_VIC) || (act == fibm_pkg::ACT_CHK_AGG);
  assign sts.need_put   = (act == fibm_pkg::ACT_SINGLE) && !is_write;
  assign sts.chk_put    = (act_r == fibm_pkg::ACT_CHK_AGG) && hit && !is_write;
  assign sts.clr_done   = clr_r == fibm_pkg::AW'(fibm_pkg::WORDS - 1);

  always_comb begin
    we = 1'b0;
    re = 1'b0;
    wa = idx_a;
    ra = idx_a;
    wd = 8'd0;
    case (cmd)
      fibm_pkg::CMD_CLEAR: begin
        we = 1'b1;
        wa = clr_r;
      end
      fibm_pkg::CMD_LOAD: begin
        re = idx_ok && kind_r <= fibm_pkg::K_RD_WORD;
        we = idx_ok && kind_r == fibm_pkg::K_WR_WORD;
        wd = wv_r;
      end
      fibm_pkg::CMD_EVAL: begin
        re = sts.need_chk || sts.need_put;
        if (act == fibm_pkg::ACT_CHK_VIC) ra = fibm_pkg::AW'(sv_e[28:3]);
        else if (act == fibm_pkg::ACT_CHK_AGG) ra = fibm_pkg::AW'(sa_e[28:3]);
      end
      fibm_pkg::CMD_CHK: begin
        we = (act_r == fibm_pkg::ACT_CHK_VIC) && hit;
        wa = fibm_pkg::AW'(ck[28:3]);
        wd = fibm_pkg::set_bit(rd_data_r, ck[2:0], fv_e);
        re = sts.chk_put;
      end
      fibm_pkg::CMD_PUT: begin
        we = 1'b1;
        wd = fibm_pkg::set_bit(rd_data_r, cell_r, fv_e);
      end
      fibm_pkg::CMD_FIN_RD: re = 1'b1;
      fibm_pkg::CMD_FIN_WR: begin
        we = 1'b1;
        wd = fibm_pkg::set_bit(rd_data_r, cell_r, val_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) rd_data_r <= mem[ra];
  end

  always_ff @(posedge clk) begin
    case (cmd)
      fibm_pkg::CMD_CAPTURE: begin
        kind_r <= in_kind;
        idx_r  <= in_word_index;
        cell_r <= in_cell_req;
        bv_r   <= in_bit_value;
        wv_r   <= in_word_value;
        sa_r   <= in_aggressor_code;
        sv_r   <= in_victim_code;
        fv_r   <= in_fault_value;
        rv_r   <= in_read_value;
      end
      fibm_pkg::CMD_LOAD: begin
        status_r <= status_nxt;
        if (kind_r == fibm_pkg::K_ADD && status_nxt == fibm_pkg::ST_OK) begin
          fa_r[count_r[fibm_pkg::FW-1:0]]  <= sa_r;
          fvc_r[count_r[fibm_pkg::FW-1:0]] <= sv_r;
          fo_r[count_r[fibm_pkg::FW-1:0]]  <= {rv_r, fv_r};
        end
      end
      fibm_pkg::CMD_CODE: begin
        if (is_write) begin
          code_r <= {1'b0, rd_data_r[cell_r], bv_r, 26'(idx_r), cell_r};
          val_r  <= bv_r;
        end else begin
          code_r <= {rd_data_r[cell_r] ? fibm_pkg::OP_RD1 : fibm_pkg::OP_RD0,
                     26'(idx_r), cell_r};
          val_r  <= rd_data_r[cell_r];
        end
      end
      fibm_pkg::CMD_EVAL: begin
        act_r <= act;
        if (act == fibm_pkg::ACT_STATE || (act == fibm_pkg::ACT_SINGLE && is_write)) begin
          val_r <= fv_e;
        end
      end
      fibm_pkg::CMD_CHK: begin
        if (act_r == fibm_pkg::ACT_CHK_AGG && hit && is_write) val_r <= fv_e;
      end
      fibm_pkg::CMD_PUT: val_r <= rv_e;
      fibm_pkg::CMD_OUT: begin
        out_bit_r    <= (kind_r == fibm_pkg::K_RD_BIT && status_r == fibm_pkg::ST_OK) & val_r;
        out_word_r   <= (kind_r == fibm_pkg::K_RD_WORD && status_r == fibm_pkg::ST_OK) ?
                        rd_data_r : 8'd0;
        out_code_r   <= last_r;
        out_status_r <= status_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      last_r      <= 32'd0;
      scan_r      <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd == fibm_pkg::CMD_CLEAR) clr_r <= clr_r + fibm_pkg::AW'(1);
      if (cmd == fibm_pkg::CMD_LOAD && kind_r == fibm_pkg::K_ADD &&
          status_nxt == fibm_pkg::ST_OK) begin
        count_r <= count_r + fibm_pkg::CW'(1);
      end
      if (cmd == fibm_pkg::CMD_CODE) begin
        scan_r <= '0;
        last_r <= is_write ? {1'b0, rd_data_r[cell_r], bv_r, 26'(idx_r), cell_r} :
                  {rd_data_r[cell_r] ? fibm_pkg::OP_RD1 : fibm_pkg::OP_RD0,
                   26'(idx_r), cell_r};
      end
      if ((cmd == fibm_pkg::CMD_EVAL && !sts.need_chk && !sts.need_put) ||
          (cmd == fibm_pkg::CMD_CHK && !sts.chk_put) || cmd == fibm_pkg::CMD_PUT) begin
        scan_r <= scan_r + fibm_pkg::CW'(1);
      end
      if (cmd == fibm_pkg::CMD_OUT) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sensed_bit = out_bit_r;
  assign out_read_word  = out_word_r;
  assign out_last_code  = out_code_r;
  assign out_status     = out_status_r;

endmodule

FILE: hdl/fibm_ctrl.sv
// ----------------------------------------------------------------------------
// fibm_ctrl
// sequencer for clearing, access handling and the fault scan
// ----------------------------------------------------------------------------
module fibm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              out_valid,
  input  logic              out_stall,
  input  fibm_pkg::dp_sts_t sts,
  output fibm_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD,
    S_CODE,
    S_EVAL,
    S_CHK,
    S_PUT,
    S_FIN_RD,
    S_FIN_WR,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = fibm_pkg::CMD_NOP;
    case (state_r)
      S_CLEAR: begin
        cmd = fibm_pkg::CMD_CLEAR;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd       = fibm_pkg::CMD_CAPTURE;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd       = fibm_pkg::CMD_LOAD;
        state_nxt = sts.bit_access ? S_CODE : S_DONE;
      end
      S_CODE: begin
        cmd       = fibm_pkg::CMD_CODE;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (sts.scan_done) begin
          state_nxt = sts.is_write ? S_FIN_RD : S_DONE;
        end else begin
          cmd = fibm_pkg::CMD_EVAL;
          if (sts.need_chk) state_nxt = S_CHK;
          else if (sts.need_put) state_nxt = S_PUT;
        end
      end
      S_CHK: begin
        cmd       = fibm_pkg::CMD_CHK;
        state_nxt = sts.chk_put ? S_PUT : S_EVAL;
      end
      S_PUT: begin
        cmd       = fibm_pkg::CMD_PUT;
        state_nxt = S_EVAL;
      end
      S_FIN_RD: begin
        cmd       = fibm_pkg::CMD_FIN_RD;
        state_nxt = S_FIN_WR;
      end
      S_FIN_WR: begin
        cmd       = fibm_pkg::CMD_FIN_WR;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd       = fibm_pkg::CMD_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

FILE: tb/tb_fault_injecting_bit_memory.sv
// ----------------------------------------------------------------------------
// tb_fault_injecting_bit_memory
// drives bit, word and fault-insertion requests into the fault injecting bit
// memory, predicts every answer with a behavioral copy of the memory and its
// fault table, and compares each answer field by field in order
// ----------------------------------------------------------------------------
module tb_fault_injecting_bit_memory;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_W00 = 3'd0;
  localparam logic [2:0] OP_W01 = 3'd1;
  localparam logic [2:0] OP_W10 = 3'd2;
  localparam logic [2:0] OP_W11 = 3'd3;
  localparam int RANDOM_ITEMS = 1200;
  localparam int SETTLE_CYCLES = 200;

  typedef struct {
    logic [2:0]  kind;
    logic [9:0]  idx;
    logic [2:0]  pos;
    logic        bv;
    logic [7:0]  wv;
    logic [31:0] sa;
    logic [31:0] sv;
    logic        fv;
    logic        rv;
  } mem_req_t;

  typedef struct {
    logic        rbit;
    logic [7:0]  rword;
    logic [31:0] code;
    logic [1:0]  status;
  } mem_answer_t;

  class fault_memory_scoreboard;
    logic [7:0]  mem [fibm_pkg::WORDS];
    logic [31:0] agg [fibm_pkg::MAX_FAULTS];
    logic [31:0] vic [fibm_pkg::MAX_FAULTS];
    logic        fval [fibm_pkg::MAX_FAULTS];
    logic        rval [fibm_pkg::MAX_FAULTS];
    int          stored;
    logic [31:0] last_code;
    mem_answer_t expected_q[$];
    int          errors;
    int          answers;
    int          bit_accesses;
    int          rejected_adds;

    function new();
      foreach (mem[i]) mem[i] = 8'h00;
      stored = 0;
      last_code = 32'h0;
      errors = 0;
      answers = 0;
      bit_accesses = 0;
      rejected_adds = 0;
    endfunction

    function logic [25:0] index_of(logic [31:0] c);
      return c[28:3];
    endfunction

    function logic read_cell(logic [25:0] idx, logic [2:0] pos);
      if (idx >= fibm_pkg::WORDS) return 1'b0;
      return mem[idx[9:0]][pos];
    endfunction

    function void write_cell(logic [25:0] idx, logic [2:0] pos, logic v);
      if (idx < fibm_pkg::WORDS) mem[idx[9:0]][pos] = v;
    endfunction

    function logic in_state(logic [31:0] c, logic b);
      return (c[31:29] == fibm_pkg::OP_STATE0 && !b) ||
             (c[31:29] == fibm_pkg::OP_STATE1 && b);
    endfunction

    function logic hits_word(int i, logic [9:0] idx);
      if (index_of(agg[i]) == 26'(idx)) return 1'b1;
      return vic[i] != 0 && index_of(vic[i]) == 26'(idx);
    endfunction

    function void bit_write(logic [9:0] idx, logic [2:0] pos, logic v);
      logic        cur;
      logic        val;
      logic [2:0]  op;
      logic [31:0] code;
      cur = read_cell(26'(idx), pos);
      val = v;
      op = cur ? (v ? OP_W11 : OP_W10) : (v ? OP_W01 : OP_W00);
      code = {op, 16'd0, idx, pos};
      last_code = code;
      for (int i = 0; i < stored; i++) begin
        if (!hits_word(i, idx)) continue;
        if (vic[i] == 0) begin
          if (code == agg[i]) val = fval[i];
          else if (agg[i] >= fibm_pkg::STATE_CODE_MIN && agg[i][2:0] == pos &&
                   in_state(agg[i], val))
            val = fval[i];
        end else if (code == agg[i]) begin
          if (vic[i] >= fibm_pkg::STATE_CODE_MIN &&
              in_state(vic[i], read_cell(index_of(vic[i]), vic[i][2:0])))
            write_cell(index_of(vic[i]), vic[i][2:0], fval[i]);
        end else if (code == vic[i]) begin
          if (agg[i] >= fibm_pkg::STATE_CODE_MIN &&
              in_state(agg[i], read_cell(index_of(agg[i]), agg[i][2:0])))
            val = fval[i];
        end
      end
      write_cell(26'(idx), pos, val);
    endfunction

    function logic bit_read(logic [9:0] idx, logic [2:0] pos);
      logic        res;
      logic [31:0] code;
      res = read_cell(26'(idx), pos);
      code = {res ? fibm_pkg::OP_RD1 : fibm_pkg::OP_RD0, 16'd0, idx, pos};
      for (int i = 0; i < stored; i++) begin
        if (!hits_word(i, idx)) continue;
        if (vic[i] == 0) begin
          if (code == agg[i]) begin
            write_cell(26'(idx), pos, fval[i]);
            res = rval[i];
          end
        end else if (code == agg[i]) begin
          if (vic[i] >= fibm_pkg::STATE_CODE_MIN &&
              in_state(vic[i], read_cell(index_of(vic[i]), vic[i][2:0])))
            write_cell(index_of(vic[i]), vic[i][2:0], fval[i]);
        end else if (code == vic[i]) begin
          if (agg[i] >= fibm_pkg::STATE_CODE_MIN &&
              in_state(agg[i], read_cell(index_of(agg[i]), agg[i][2:0]))) begin
            write_cell(26'(idx), pos, fval[i]);
            res = rval[i];
          end
        end
      end
      last_code = code;
      return res;
    endfunction

    function void note_request(mem_req_t r);
      mem_answer_t a;
      a.rbit = 1'b0;
      a.rword = 8'h00;
      a.status = fibm_pkg::ST_OK;
      if (r.kind <= fibm_pkg::K_WR_WORD && r.idx >= fibm_pkg::WORDS) begin
        a.status = fibm_pkg::ST_RANGE;
      end else if (r.kind == fibm_pkg::K_RD_BIT) begin
        a.rbit = bit_read(r.idx, r.pos);
        bit_accesses++;
      end else if (r.kind == fibm_pkg::K_WR_BIT) begin
        bit_write(r.idx, r.pos, r.bv);
        bit_accesses++;
      end else if (r.kind == fibm_pkg::K_RD_WORD) begin
        a.rword = mem[r.idx];
      end else if (r.kind == fibm_pkg::K_WR_WORD) begin
        mem[r.idx] = r.wv;
      end else if (r.kind == fibm_pkg::K_ADD) begin
        if (index_of(r.sa) >= fibm_pkg::WORDS ||
            (r.sv != 0 && index_of(r.sv) >= fibm_pkg::WORDS)) begin
          a.status = fibm_pkg::ST_RANGE;
          rejected_adds++;
        end else if (stored >= fibm_pkg::MAX_FAULTS) begin
          a.status = fibm_pkg::ST_FULL;
          rejected_adds++;
        end else begin
          agg[stored] = r.sa;
          vic[stored] = r.sv;
          fval[stored] = r.fv;
          rval[stored] = r.rv;
          stored++;
        end
      end
      a.code = last_code;
      expected_q.push_back(a);
    endfunction

    function void check_answer(mem_answer_t got);
      mem_answer_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word rbit %h rword %h code %h status %h", $time,
                 got.rbit, got.rword, got.code, got.status);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      answers++;
      if (got.rbit !== e.rbit) begin
        $display("%0t: sensed_bit expected %h actual %h", $time, e.rbit, got.rbit);
        errors++;
      end
      if (got.rword !== e.rword) begin
        $display("%0t: read_word expected %h actual %h", $time, e.rword, got.rword);
        errors++;
      end
      if (got.code !== e.code) begin
        $display("%0t: last_code expected %h actual %h", $time, e.code, got.code);
        errors++;
      end
      if (got.status !== e.status) begin
        $display("%0t: status expected %h actual %h", $time, e.status, got.status);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_kind = '0;
  logic [9:0]  in_word_index = '0;
  logic [2:0]  in_cell_req = '0;
  logic        in_bit_value = 1'b0;
  logic [7:0]  in_word_value = '0;
  logic [31:0] in_aggressor_code = '0;
  logic [31:0] in_victim_code = '0;
  logic        in_fault_value = 1'b0;
  logic        in_read_value = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_sensed_bit;
  logic [7:0]  out_read_word;
  logic [31:0] out_last_code;
  logic [1:0]  out_status;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  fault_memory_scoreboard sb = new();

  fault_injecting_bit_memory dut (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    mem_req_t    r;
    mem_answer_t a;
    if (rst_n && in_valid && !in_stall) begin
      r = '{in_kind, in_word_index, in_cell_req, in_bit_value, in_word_value,
            in_aggressor_code, in_victim_code, in_fault_value, in_read_value};
      sb.note_request(r);
    end
    if (rst_n && out_valid && !out_stall) begin
      a = '{out_sensed_bit, out_read_word, out_last_code, out_status};
      sb.check_answer(a);
    end
  end

  function automatic logic [31:0] fault_code(logic [2:0] op, logic [9:0] idx, logic [2:0] pos);
    return {op, 16'd0, idx, pos};
  endfunction

  function automatic mem_req_t make_req(logic [2:0] kind, logic [9:0] idx, logic [2:0] pos,
                                        logic bv, logic [7:0] wv, logic [31:0] sa,
                                        logic [31:0] sv, logic fv, logic rv);
    mem_req_t r;
    r = '{kind, idx, pos, bv, wv, sa, sv, fv, rv};
    return r;
  endfunction

  function automatic logic [9:0] pick_word();
    if ($urandom_range(0, 99) < 85) return 10'($urandom_range(0, 7));
    return 10'($urandom_range(0, fibm_pkg::WORDS - 1));
  endfunction

  function automatic logic [31:0] pick_code(bit want_state);
    logic [2:0] op;
    op = want_state ? 3'($urandom_range(fibm_pkg::OP_STATE0, fibm_pkg::OP_STATE1)) :
                      3'($urandom_range(0, 7));
    if ($urandom_range(0, 99) < 6) return $urandom();
    return fault_code(op, pick_word(), 3'($urandom_range(0, 7)));
  endfunction

  function automatic mem_req_t random_req();
    mem_req_t r;
    int       sel;
    r.idx = pick_word();
    r.pos = 3'($urandom_range(0, 7));
    r.bv = 1'($urandom_range(0, 1));
    r.wv = 8'($urandom_range(0, 255));
    r.fv = 1'($urandom_range(0, 1));
    r.rv = 1'($urandom_range(0, 1));
    r.sa = pick_code(0);
    r.sv = ($urandom_range(0, 99) < 40) ? 32'h0 : pick_code($urandom_range(0, 99) < 80);
    sel = $urandom_range(0, 99);
    if (sel < 35) r.kind = fibm_pkg::K_RD_BIT;
    else if (sel < 70) r.kind = fibm_pkg::K_WR_BIT;
    else if (sel < 80) r.kind = fibm_pkg::K_RD_WORD;
    else if (sel < 90) r.kind = fibm_pkg::K_WR_WORD;
    else if (sel < 96) r.kind = fibm_pkg::K_ADD;
    else r.kind = 3'($urandom_range(fibm_pkg::K_ADD + 1, 7));
    return r;
  endfunction

  task automatic send(mem_req_t r);
    int gap;
    in_valid <= 1'b1;
    in_kind <= r.kind;
    in_word_index <= r.idx;
    in_cell_req <= r.pos;
    in_bit_value <= r.bv;
    in_word_value <= r.wv;
    in_aggressor_code <= r.sa;
    in_victim_code <= r.sv;
    in_fault_value <= r.fv;
    in_read_value <= r.rv;
    do @(posedge clk); while (in_stall);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    mem_req_t directed[$];
    int       settle;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-cell transition, read and state faults, then two coupling faults
    directed.push_back(make_req(fibm_pkg::K_ADD, 0, 0, 0, 0, fault_code(OP_W01, 1, 0),
                                0, 0, 0));
    directed.push_back(make_req(fibm_pkg::K_ADD, 0, 0, 0, 0,
                                fault_code(fibm_pkg::OP_RD0, 2, 1), 0, 1, 1));
    directed.push_back(make_req(fibm_pkg::K_ADD, 0, 0, 0, 0,
                                fault_code(fibm_pkg::OP_STATE0, 3, 2), 0, 1, 0));
    directed.push_back(make_req(fibm_pkg::K_ADD, 0, 0, 0, 0, fault_code(OP_W01, 4, 0),
                                fault_code(fibm_pkg::OP_STATE0, 5, 5), 1, 0));
    directed.push_back(make_req(fibm_pkg::K_ADD, 0, 0, 0, 0,
                                fault_code(fibm_pkg::OP_STATE1, 4, 7),
                                fault_code(fibm_pkg::OP_RD0, 6, 3), 1, 1));
    // codes outside the memory
    directed.push_back(make_req(fibm_pkg::K_ADD, 0, 0, 0, 0, 32'h1FFF_FFF8, 0, 1, 1));
    directed.push_back(make_req(fibm_pkg::K_ADD, 0, 0, 0, 0, fault_code(OP_W00, 0, 0),
                                32'hFFFF_FFFF, 1, 1));
    directed.push_back(make_req(fibm_pkg::K_WR_BIT, 1, 0, 1, 0, 0, 0, 0, 0));
    directed.push_back(make_req(fibm_pkg::K_RD_BIT, 1, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_req(fibm_pkg::K_RD_BIT, 2, 1, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_req(fibm_pkg::K_RD_BIT, 2, 1, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_req(fibm_pkg::K_WR_BIT, 3, 2, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_req(fibm_pkg::K_WR_BIT, 3, 3, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_req(fibm_pkg::K_RD_WORD, 3, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_req(fibm_pkg::K_WR_BIT, 4, 0, 1, 0, 0, 0, 0, 0));
    directed.push_back(make_req(fibm_pkg::K_RD_WORD, 5, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_req(fibm_pkg::K_WR_WORD, 4, 0, 0, 8'h80, 0, 0, 0, 0));
    directed.push_back(make_req(fibm_pkg::K_RD_BIT, 6, 3, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_req(fibm_pkg::K_WR_WORD, 0, 0, 0, 8'hFF, 0, 0, 0, 0));
    directed.push_back(make_req(fibm_pkg::K_RD_WORD, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_req(fibm_pkg::K_WR_BIT, 1023, 7, 1, 0, 0, 0, 0, 0));
    directed.push_back(make_req(fibm_pkg::K_RD_BIT, 1023, 7, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_req(fibm_pkg::K_RD_WORD, 1023, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_req(3'(fibm_pkg::K_ADD + 1), 1023, 7, 1, 8'hFF, 32'hFFFF_FFFF,
                                32'hFFFF_FFFF, 1, 1));
    directed.push_back(make_req(3'd7, 0, 0, 0, 0, 0, 0, 0, 0));
    foreach (directed[i]) send(directed[i]);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i < 400) begin
        send_idle_pct = 30;
        recv_idle_pct = 72;
      end else if (i < 800) begin
        send_idle_pct = 72;
        recv_idle_pct = 30;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (i == 600) begin
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
      end
      send(random_req());
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    settle = 0;
    while (settle < SETTLE_CYCLES) begin
      @(posedge clk);
      settle++;
    end
    $display("covered %0d answers, %0d bit accesses, %0d faults stored, %0d adds refused",
             sb.answers, sb.bit_accesses, sb.stored, sb.rejected_adds);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS fault_injecting_bit_memory");
    end else begin
      $display("FAIL fault_injecting_bit_memory");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL fault_injecting_bit_memory");
    $finish;
  end

endmodule
